### sv/qcpd_pkg.sv
// Package: shared types and widths for the curve distance block.
package qcpd_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int SqW    = 34;
  localparam int SumW   = 35;
  localparam int RootW  = 18;
  localparam int OutW   = 17;
  localparam int WeightW = 17;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
  } curve_t;

endpackage

### sv/qcpd_cell.sv
// One sample cell: evaluates the curve at a fixed parameter and keeps the running minimum.
module qcpd_cell
  import qcpd_pkg::*;
#(
  parameter int K = 0,
  parameter int S = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_have,
  input  curve_t           in_curve,
  input  logic [SumW-1:0]  in_best,
  output logic             out_valid,
  output logic             out_have,
  output curve_t           out_curve,
  output logic [SumW-1:0]  out_best,
  input  logic             adv
);

  // Outer weights (n/s)^2 with 16 fraction bits, rounded half up.
  localparam longint Den  = longint'(S) * longint'(S);
  localparam longint RemK = longint'(S - K);
  localparam longint CurK = longint'(K);
  localparam logic [WeightW-1:0] W0 =
    WeightW'((2 * RemK * RemK * 65536 + Den) / (2 * Den));
  localparam logic [WeightW-1:0] W2 =
    WeightW'((2 * CurK * CurK * 65536 + Den) / (2 * Den));
  localparam logic [WeightW-1:0] W1 =
    (W0 + W2 >= WeightW'(65536)) ? '0 : WeightW'(65536) - W0 - W2;

  // stage 1 registers
  logic                     v1;
  logic                     h1;
  curve_t                   c1;
  logic [SumW-1:0]          b1;
  logic signed [34:0]       mx [3];
  logic signed [34:0]       my [3];
  // stage 2 registers
  logic                     v2;
  logic                     h2;
  curve_t                   c2;
  logic [SumW-1:0]          b2;
  logic [DiffW-1:0]         mag_x;
  logic [DiffW-1:0]         mag_y;
  // stage 3 registers
  logic                     v3;
  logic                     h3;
  curve_t                   c3;
  logic [SumW-1:0]          b3;
  logic [SqW-1:0]           sqx;
  logic [SqW-1:0]           sqy;

  logic signed [36:0]       accx, accy;
  logic signed [20:0]       bx, by;
  logic signed [DiffW-1:0]  dx, dy;
  logic [DiffW-1:0]         ax, ay;
  logic [SumW-1:0]          d2;

  // combine products, round half up to whole coordinate units, take differences
  always_comb begin
    accx = 37'(mx[0]) + 37'(mx[1]) + 37'(mx[2]) + 37'sd32768;
    accy = 37'(my[0]) + 37'(my[1]) + 37'(my[2]) + 37'sd32768;
    bx   = accx[36:16];
    by   = accy[36:16];
    dx   = DiffW'(21'(c1.px) - bx);
    dy   = DiffW'(21'(c1.py) - by);
    ax   = dx[DiffW-1] ? DiffW'(-dx) : dx;
    ay   = dy[DiffW-1] ? DiffW'(-dy) : dy;
    d2   = SumW'(sqx) + SumW'(sqy);
  end

  // advance the cell pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    if (adv) begin
      h1 <= in_have;
      c1 <= in_curve;
      b1 <= in_best;
      mx[0] <= 35'(in_curve.sx * $signed({1'b0, W0}));
      mx[1] <= 35'(in_curve.cx * $signed({1'b0, W1}));
      mx[2] <= 35'(in_curve.ex * $signed({1'b0, W2}));
      my[0] <= 35'(in_curve.sy * $signed({1'b0, W0}));
      my[1] <= 35'(in_curve.cy * $signed({1'b0, W1}));
      my[2] <= 35'(in_curve.ey * $signed({1'b0, W2}));
      h2    <= h1;
      c2    <= c1;
      b2    <= b1;
      mag_x <= ax;
      mag_y <= ay;
      h3  <= h2;
      c3  <= c2;
      b3  <= b2;
      sqx <= SqW'(mag_x * mag_x);
      sqy <= SqW'(mag_y * mag_y);
      out_curve <= c3;
      out_have  <= 1'b1;
      out_best  <= (!h3 || d2 < b3) ? d2 : b3;
    end
  end

endmodule

### sv/qcpd_sqrt.sv
// Pipelined rounded integer square root, two result bits per stage.
module qcpd_sqrt
  import qcpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [SumW-1:0]  in_value,
  output logic             out_valid,
  output logic [OutW-1:0]  out_root
);

  localparam int Steps = RootW;
  localparam int Stages = Steps / 2;
  localparam int RemW = RootW + 2;
  localparam int ValW = 2 * RootW;

  logic            v   [Stages+1];
  logic [ValW-1:0] val [Stages+1];
  logic [RemW-1:0] rem [Stages+1];
  logic [RootW-1:0] rt [Stages+1];
  logic            vf;
  logic [RootW-1:0] rf;
  logic [RemW-1:0] remf;

  assign v[0]   = in_valid;
  assign val[0] = ValW'(in_value);
  assign rem[0] = '0;
  assign rt[0]  = '0;

  // one stage: two restoring steps
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [ValW-1:0]  vn;
    logic [RemW-1:0]  rn;
    logic [RootW-1:0] qn;
    logic [RemW-1:0]  r_a, t_a;
    logic [RootW-1:0] q_a;
    always_comb begin
      r_a = {rem[g][RemW-3:0], val[g][ValW-1 -: 2]};
      t_a = {rt[g][RemW-3:0], 2'b01};
      if (r_a >= t_a) begin
        r_a = r_a - t_a;
        q_a = {rt[g][RootW-2:0], 1'b1};
      end else begin
        q_a = {rt[g][RootW-2:0], 1'b0};
      end
      rn = {r_a[RemW-3:0], val[g][ValW-3 -: 2]};
      t_a = {q_a[RemW-3:0], 2'b01};
      if (rn >= t_a) begin
        rn = rn - t_a;
        qn = {q_a[RootW-2:0], 1'b1};
      end else begin
        qn = {q_a[RootW-2:0], 1'b0};
      end
      vn = {val[g][ValW-5:0], 4'b0};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (adv) begin
        v[g+1] <= v[g];
      end
      if (adv) begin
        val[g+1] <= vn;
        rem[g+1] <= rn;
        rt[g+1]  <= qn;
      end
    end
  end

  // round to nearest: bump when remainder exceeds root
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= v[Stages];
    end
    if (adv) begin
      rf   <= rt[Stages];
      remf <= rem[Stages];
    end
  end

  assign out_valid = vf;
  assign out_root  = (remf > RemW'(rf)) ? OutW'(rf + 1'b1) : OutW'(rf);

endmodule

### sv/quadratic_curve_point_distance.sv
// Top level: sampled distance from a point to a quadratic Bezier curve.
//
//   channel | dir | payload
//   s_axis  | in  | tdata: point_x, point_y, start_x, start_y, control_x, control_y, end_x, end_y
//   m_axis  | out | tdata: nearest_distance (17 bits, zero filled to 24)
//
// One query enters per cycle while the output is not stalled; it passes through the row of
// sample cells, the root pipeline and the output register. The row of sample cells and the
// root pipeline move together; a stalled output register with a full slot freezes the whole row.
// Reset (rst, synchronous) clears all valid flags; payload registers are not reset.
module quadratic_curve_point_distance
  import qcpd_pkg::*;
#(
  parameter int SAMPLES = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // point_x, point_y, start_x, start_y,
                                       // control_x, control_y, end_x, end_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata    // nearest_distance
);

  localparam int S = (SAMPLES < 1) ? 1 : SAMPLES;

  logic             adv;
  logic             cv [S+2];
  logic             ch [S+2];
  curve_t           cc [S+2];
  logic [SumW-1:0]  cb [S+2];
  logic             rv;
  logic [OutW-1:0]  rr;

  // fill the row when the output slot can take what leaves it
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign cv[0] = s_axis_tvalid;
  assign ch[0] = 1'b0;
  assign cb[0] = '0;
  assign cc[0] = '{px: s_axis_tdata[15:0],    py: s_axis_tdata[31:16],
                   sx: s_axis_tdata[47:32],   sy: s_axis_tdata[63:48],
                   cx: s_axis_tdata[79:64],   cy: s_axis_tdata[95:80],
                   ex: s_axis_tdata[111:96],  ey: s_axis_tdata[127:112]};

  // row of sample cells, one per parameter value
  for (genvar k = 0; k <= S; k++) begin : g_cell
    qcpd_cell #(.K(k), .S(S)) u_cell (
      .clk, .rst, .adv,
      .in_valid(cv[k]), .in_have(ch[k]), .in_curve(cc[k]), .in_best(cb[k]),
      .out_valid(cv[k+1]), .out_have(ch[k+1]), .out_curve(cc[k+1]), .out_best(cb[k+1])
    );
  end

  qcpd_sqrt u_sqrt (
    .clk, .rst, .adv,
    .in_valid(cv[S+1]), .in_value(cb[S+1]),
    .out_valid(rv), .out_root(rr)
  );

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= rv;
    end
    if (adv) begin
      m_axis_tdata <= {7'b0, rr};
    end
  end

endmodule
